/* rtl/pbbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbbd_pkg
// Shared widths, codes and types for the palette byte box downsampler.
// ----------------------------------------------------------------------------
package pbbd_pkg;

    localparam int COLOR_W          = 8;
    localparam int IDX_W            = 8;
    localparam int PALETTE_DEPTH    = 1 << IDX_W;
    localparam int SHIFT_W          = 5;
    localparam int MAX_GROUP_SHIFT  = 16;
    localparam int PIXEL_INDEX_BITS = 24;
    localparam int SUM_W            = COLOR_W + MAX_GROUP_SHIFT;
    localparam int CNT_W            = MAX_GROUP_SHIFT + 1;

    // tuser codes on the input stream
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [PIXEL_INDEX_BITS-1:0] index;
        logic [COLOR_W-1:0]          blue;
        logic [COLOR_W-1:0]          green;
        logic [COLOR_W-1:0]          red;
        logic                        final_pixel;
    } t_pixel;

endpackage

/* rtl/pbbd_palette.sv */
// ----------------------------------------------------------------------------
// pbbd_palette
// 256 x 24 palette RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbbd_palette
    import pbbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_rgb             i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_rgb             o_rdata
);

    t_rgb r_mem [PALETTE_DEPTH];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued (downstream stall)
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pbbd_accum.sv */
// ----------------------------------------------------------------------------
// pbbd_accum
// Group accumulator: adds palette colors, closes groups, holds the pixel
// output register.
// ----------------------------------------------------------------------------
module pbbd_accum
    import pbbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,      // data byte transfer this edge
    input  logic               i_eof,
    input  t_rgb               i_color,     // palette read data of stage 1
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic               i_out_ready,
    output logic               o_ready,
    output logic               o_out_valid,
    output t_pixel             o_pixel
);

    logic                        r_s1_valid;
    logic                        r_s1_eof;
    logic [SUM_W-1:0]            r_red_sum, r_green_sum, r_blue_sum;
    logic [CNT_W-1:0]            r_count;
    logic [PIXEL_INDEX_BITS-1:0] r_pix_cnt;
    logic                        r_out_valid;
    t_pixel                      r_pixel;

    logic [SUM_W-1:0]   n_red_sum, n_green_sum, n_blue_sum;
    logic [CNT_W-1:0]   n_count;
    logic [SHIFT_W-1:0] eff_shift;
    logic [CNT_W-1:0]   group_size;
    logic               close;
    logic               advance;
    logic [SUM_W-1:0]   red_avg, green_avg, blue_avg;

    always_comb begin
        eff_shift   = (i_shift > SHIFT_W'(MAX_GROUP_SHIFT)) ?
                      SHIFT_W'(MAX_GROUP_SHIFT) : i_shift;
        group_size  = CNT_W'(1) << eff_shift;
        n_red_sum   = r_red_sum   + SUM_W'(i_color.red);
        n_green_sum = r_green_sum + SUM_W'(i_color.green);
        n_blue_sum  = r_blue_sum  + SUM_W'(i_color.blue);
        n_count     = r_count + CNT_W'(1);
        close       = (n_count >= group_size) || r_s1_eof;
        red_avg     = n_red_sum   >> eff_shift;
        green_avg   = n_green_sum >> eff_shift;
        blue_avg    = n_blue_sum  >> eff_shift;
        advance     = r_s1_valid && (!close || !r_out_valid || i_out_ready);
    end

    assign o_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_s1_eof <= i_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_sum   <= '0;
            r_green_sum <= '0;
            r_blue_sum  <= '0;
            r_count     <= '0;
            r_pix_cnt   <= '0;
        end else if (advance) begin
            if (close) begin
                r_red_sum   <= '0;
                r_green_sum <= '0;
                r_blue_sum  <= '0;
                r_count     <= '0;
                r_pix_cnt   <= r_s1_eof ? '0 : r_pix_cnt + PIXEL_INDEX_BITS'(1);
            end else begin
                r_red_sum   <= n_red_sum;
                r_green_sum <= n_green_sum;
                r_blue_sum  <= n_blue_sum;
                r_count     <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && close) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close) begin
            r_pixel.red         <= red_avg[COLOR_W-1:0];
            r_pixel.green       <= green_avg[COLOR_W-1:0];
            r_pixel.blue        <= blue_avg[COLOR_W-1:0];
            r_pixel.index       <= r_pix_cnt;
            r_pixel.final_pixel <= r_s1_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;

endmodule

/* rtl/palette_byte_box_downsampler.sv */
// ----------------------------------------------------------------------------
// palette_byte_box_downsampler
// File bytes to averaged 24-bit overview pixels through a 256-entry palette.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per transfer. tuser = 0 marks a file byte,
//   tuser = 1 a palette write (byte_value is then the palette index). tlast
//   flags the last byte of a file and flushes a partial group; missing bytes
//   count as zero and the sums are still divided by the full group size.
//   Master stream carries one pixel per closed group; tlast = final pixel.
//   Load the palette before data; write group_shift (clamped to 16) only
//   while the block is idle. A partial group survives a shift change.
//   Throughput: one item per cycle unless a held pixel stalls tready; the
//   palette RAM has one read and one write port and the three color sums
//   update together. A closing byte's pixel passes the palette read
//   register, then the output register, before it is offered.
//   Receiver stall: the output register holds the pixel; bytes that do not
//   close a group keep flowing, and tready drops only when a second pixel
//   would be needed before the first is taken.
//   Reset: sums, byte count, pixel index and group_shift clear; palette
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module palette_byte_box_downsampler
    import pbbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SHIFT_W-1:0]   i_cfg_wdata,   // group_shift
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [7:0] byte_value, [15:8] entry_red, [23:16] entry_green,
    // [31:24] entry_blue
    input  logic [31:0]          i_s_tdata,
    input  logic                 i_s_tuser,     // [0] kind
    input  logic                 i_s_tlast,     // end_of_file
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue,
    // [47:24] pixel_index
    output logic [47:0]          o_m_tdata,
    output logic                 o_m_tlast      // final_pixel
);

    logic [SHIFT_W-1:0] r_group_shift;
    logic               acc_ready;
    logic               xfer;
    logic               load_byte;
    logic               pal_write;
    t_rgb               wr_color;
    t_rgb               rd_color;
    t_pixel             pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_shift <= '0;
        end else if (i_cfg_we) begin
            r_group_shift <= i_cfg_wdata;
        end
    end

    assign o_s_tready = acc_ready;
    assign xfer       = i_s_tvalid && acc_ready;
    assign load_byte  = xfer && (i_s_tuser == KIND_DATA);
    assign pal_write  = xfer && (i_s_tuser == KIND_PALETTE);

    assign wr_color.red   = i_s_tdata[15:8];
    assign wr_color.green = i_s_tdata[23:16];
    assign wr_color.blue  = i_s_tdata[31:24];

    // a write lands before the next transfer's read, so no bypass is needed
    pbbd_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_write),
        .i_waddr (i_s_tdata[IDX_W-1:0]),
        .i_wdata (wr_color),
        .i_re    (load_byte),
        .i_raddr (i_s_tdata[IDX_W-1:0]),
        .o_rdata (rd_color)
    );

    pbbd_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_byte),
        .i_eof       (i_s_tlast),
        .i_color     (rd_color),
        .i_shift     (r_group_shift),
        .i_out_ready (i_m_tready),
        .o_ready     (acc_ready),
        .o_out_valid (o_m_tvalid),
        .o_pixel     (pixel)
    );

    assign o_m_tdata = {pixel.index, pixel.blue, pixel.green, pixel.red};
    assign o_m_tlast = pixel.final_pixel;

endmodule
